### rtl/jsu_pkg.sv
// jsu_pkg: shared types, status codes and constants of the json string unescaper
// no dependencies; read first by every other file of the block
package jsu_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned CP_W     = 16;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DATA       = 4'd0;
  localparam logic [STATUS_W-1:0] ST_CLOSED     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_NO_QUOTE   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_CTRL_CHAR  = 4'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_ESC    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_HEX    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_UNTERM     = 4'd6;
  localparam logic [STATUS_W-1:0] ST_END_IN_ESC = 4'd7;
  localparam logic [STATUS_W-1:0] ST_SHORT_UNI  = 4'd8;
  localparam logic [STATUS_W-1:0] ST_MAX        = ST_SHORT_UNI;

  // utf-8 framing
  localparam logic [BYTE_W-1:0] UTF8_LEAD2 = 8'hc0;
  localparam logic [BYTE_W-1:0] UTF8_LEAD3 = 8'he0;
  localparam logic [BYTE_W-1:0] UTF8_CONT  = 8'h80;

  // one queued job: either a single result beat or a code point to encode
  typedef struct packed {
    logic                is_cp;
    logic [CP_W-1:0]     value;
    logic [STATUS_W-1:0] status;
  } cmd_t;

endpackage

### rtl/jsu_if.sv
// jsu_if: valid/ready stream interfaces for source bytes and decoded results
// depends on jsu_pkg for field widths
interface jsu_in_if;
  import jsu_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_req;
  logic              source_end;

  modport source (output valid, output byte_req, output source_end, input ready);
  modport sink   (input valid, input byte_req, input source_end, output ready);
endinterface

interface jsu_out_if;
  import jsu_pkg::*;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

### rtl/jsu_front.sv
// jsu_front: takes source beats, tracks string/escape/hex state, queues jobs
// depends on jsu_pkg and jsu_in_if
module jsu_front import jsu_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  jsu_in_if.sink in_i,
  input  logic   q_full_i,
  output logic   push_o,
  output cmd_t   cmd_o
);

  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  localparam logic [1:0] HEX_LAST = 2'd3;

  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2f;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0c;

  logic [1:0]      mode_q, mode_d;
  logic [1:0]      hex_cnt_q, hex_cnt_d;
  logic [CP_W-1:0] cp_q, cp_d;
  logic            bad_q, bad_d;

  logic            accept;
  logic            gen;
  cmd_t            cmd;
  logic [BYTE_W-1:0] c;
  logic            is_hex;
  logic [3:0]      nib;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.byte_req;

  always_comb begin
    is_hex = 1'b1;
    nib    = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      nib = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      nib = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    mode_d     = mode_q;
    hex_cnt_d  = hex_cnt_q;
    cp_d       = cp_q;
    bad_d      = bad_q;
    gen        = 1'b0;
    cmd.is_cp  = 1'b0;
    cmd.value  = '0;
    cmd.status = ST_DATA;
    unique case (mode_q)
      MODE_WAIT: begin
        if (in_i.source_end) begin
          gen = 1'b1; cmd.status = ST_NO_QUOTE;
        end else if (c == CH_QUOTE) begin
          mode_d = MODE_STR;
        end else if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)) begin
          gen = 1'b1; cmd.status = ST_NO_QUOTE;
        end
      end
      MODE_STR: begin
        if (in_i.source_end) begin
          gen = 1'b1; cmd.status = ST_UNTERM;
        end else if (c == CH_QUOTE) begin
          gen = 1'b1; cmd.status = ST_CLOSED;
        end else if (c < CH_SPACE) begin
          gen = 1'b1; cmd.status = ST_CTRL_CHAR;
        end else if (c == CH_BSL) begin
          mode_d = MODE_ESC;
        end else begin
          gen = 1'b1; cmd.value = {8'h00, c};
        end
      end
      MODE_ESC: begin
        gen    = 1'b1;
        mode_d = MODE_STR;
        if (in_i.source_end) begin
          cmd.status = ST_END_IN_ESC;
        end else begin
          unique case (c)
            CH_QUOTE, CH_BSL, CH_SLASH: cmd.value = {8'h00, c};
            8'h62:   cmd.value = {8'h00, CH_BS};
            8'h66:   cmd.value = {8'h00, CH_FF};
            8'h6e:   cmd.value = {8'h00, CH_LF};
            8'h72:   cmd.value = {8'h00, CH_CR};
            8'h74:   cmd.value = {8'h00, CH_TAB};
            8'h75: begin
              gen       = 1'b0;
              mode_d    = MODE_HEX;
              hex_cnt_d = '0;
              cp_d      = '0;
              bad_d     = 1'b0;
            end
            default: cmd.status = ST_BAD_ESC;
          endcase
        end
      end
      MODE_HEX: begin
        if (in_i.source_end) begin
          gen = 1'b1; cmd.status = ST_SHORT_UNI;
        end else begin
          cp_d  = {cp_q[CP_W-5:0], nib};
          bad_d = bad_q || !is_hex;
          if (hex_cnt_q != HEX_LAST) begin
            hex_cnt_d = hex_cnt_q + 2'd1;
          end else begin
            hex_cnt_d = '0;
            gen       = 1'b1;
            mode_d    = MODE_STR;
            if (bad_d) begin
              cmd.status = ST_BAD_HEX;
            end else begin
              cmd.is_cp = 1'b1;
              cmd.value = cp_d;
            end
          end
        end
      end
      default: ;
    endcase
    // every non-data status drops back to waiting for a quote
    if (gen && cmd.status != ST_DATA) begin
      mode_d    = MODE_WAIT;
      hex_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_WAIT;
      hex_cnt_q <= '0;
      cp_q      <= '0;
      bad_q     <= 1'b0;
    end else if (accept) begin
      mode_q    <= mode_d;
      hex_cnt_q <= hex_cnt_d;
      cp_q      <= cp_d;
      bad_q     <= bad_d;
    end
  end

  assign push_o = accept && gen;
  assign cmd_o  = cmd;

endmodule

### rtl/jsu_fifo.sv
// jsu_fifo: short job queue between front and back
// depends on jsu_pkg for the job type
module jsu_fifo import jsu_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output cmd_t head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(Depth - 1);

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/jsu_back.sv
// jsu_back: expands queued jobs into result beats, utf-8 encoding code points
// depends on jsu_pkg and jsu_out_if
module jsu_back import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  jsu_out_if.source  out_o
);

  logic              valid_q;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [STATUS_W-1:0] status_q;
  logic              last_q, last_d;
  logic [1:0]        idx_q;
  logic [1:0]        nb_m1;
  logic              load;
  logic [CP_W-1:0]   v;

  assign v    = head_i.value;
  assign load = !empty_i && (!valid_q || out_o.ready);

  // bytes per job minus one
  always_comb begin
    if (!head_i.is_cp || v[CP_W-1:7] == '0) begin
      nb_m1 = 2'd0;
    end else if (v[CP_W-1:11] == '0) begin
      nb_m1 = 2'd1;
    end else begin
      nb_m1 = 2'd2;
    end
  end

  always_comb begin
    byte_d = v[BYTE_W-1:0];
    if (head_i.is_cp) begin
      unique case (nb_m1)
        2'd0: byte_d = {1'b0, v[6:0]};
        2'd1: byte_d = (idx_q == 2'd0) ? (UTF8_LEAD2 | {3'b000, v[10:6]})
                                       : (UTF8_CONT | {2'b00, v[5:0]});
        2'd2: begin
          priority if (idx_q == 2'd0) begin
            byte_d = UTF8_LEAD3 | {4'b0000, v[15:12]};
          end else if (idx_q == 2'd1) begin
            byte_d = UTF8_CONT | {2'b00, v[11:6]};
          end else begin
            byte_d = UTF8_CONT | {2'b00, v[5:0]};
          end
        end
        default: byte_d = '0;
      endcase
    end
  end

  assign last_d = (idx_q == nb_m1);
  assign pop_o  = load && last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last_d ? 2'd0 : idx_q + 2'd1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= byte_d;
      status_q <= head_i.status;
      last_q   <= last_d;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.out_byte = byte_q;
  assign out_o.status   = status_q;
  assign out_o.last     = last_q;

endmodule

### rtl/json_string_unescape.sv
// json_string_unescape: one source beat in per cycle while the job queue is not full;
// one result beat out per cycle while the sink is ready; a \u escape gives up to three
// result beats, drained by the output stage at one a cycle while the job queue absorbs input
// reset (async, active low) empties the queue and output stage and returns to awaiting a quote
// depends on jsu_pkg, jsu_if, jsu_front, jsu_fifo, jsu_back
module json_string_unescape import jsu_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH  // job queue depth, two or more
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  jsu_in_if.sink     in_i,
  jsu_out_if.source  out_o
);

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic q_full;

  // queue to back
  logic q_empty;
  logic pop;
  cmd_t head;

  // front: whitespace skip, quote check, escape and hex collection;
  // it stalls the source only while the queue is full
  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // decouples the single-beat front from the multi-beat utf-8 back end
  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (pop),
    .head_o  (head)
  );

  // back: one result beat per cycle while the sink is ready, into a registered output stage
  jsu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

### rtl/jsu_checker.sv
// jsu_checker: port-level assertions on result beats of json_string_unescape
// depends on jsu_pkg; attached to the top level by bind
module jsu_checker import jsu_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid,
  input logic                out_ready,
  input logic [BYTE_W-1:0]   out_byte,
  input logic [STATUS_W-1:0] status,
  input logic                last
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status)
                                && $stable(last))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> status <= ST_MAX)
    else $error("status code out of range");

  // status beats stand alone and carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != ST_DATA |-> last && out_byte == '0)
    else $error("status beat not last or byte not zero");

  // only utf-8 lead and continuation bytes are followed by more beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !last |-> status == ST_DATA && out_byte[BYTE_W-1])
    else $error("non-last beat is not a multi-byte utf-8 byte");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_byte  (out_o.out_byte),
  .status    (out_o.status),
  .last      (out_o.last)
);

### test/testbench.sv
// testbench for json_string_unescape: directed and random source beats, checked against
// a built-in decoder model, with random idling on both streams
// depends on jsu_pkg, jsu_if and the block's rtl
`timescale 1ns / 100ps

module testbench;
  import jsu_pkg::*;

  // source characters that the decoder treats specially
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2f;
  localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_BKSP   = 8'h08;
  localparam logic [BYTE_W-1:0] CH_FF     = 8'h0c;
  localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7f;
  // letters after a backslash that name a single-character escape
  localparam logic [BYTE_W-1:0] ESC_B     = 8'h62;
  localparam logic [BYTE_W-1:0] ESC_F     = 8'h66;
  localparam logic [BYTE_W-1:0] ESC_N     = 8'h6e;
  localparam logic [BYTE_W-1:0] ESC_R     = 8'h72;
  localparam logic [BYTE_W-1:0] ESC_T     = 8'h74;

  localparam int unsigned RANDOM_BEATS   = 70;
  localparam int unsigned CALM_BEATS     = 30;   // stretch with no idling on either side
  localparam int unsigned IDLE_PERCENT   = 35;
  localparam int unsigned SETTLE_CYCLES  = 20;   // ample for any stray result to show
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  typedef enum logic [1:0] {
    AWAIT_QUOTE,
    IN_STRING,
    AFTER_BACKSLASH,
    IN_HEX
  } scan_mode_e;

  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

  // decoder model plus the queue of results it still owes
  class unescape_scoreboard;
    result_t     due_results[$];
    result_t     beat_out[$];
    scan_mode_e  mode;
    logic [1:0]  hex_count;
    logic [15:0] code_point;
    logic        bad_digit;
    int unsigned failures;
    int unsigned checked;

    function new();
      mode       = AWAIT_QUOTE;
      hex_count  = '0;
      code_point = '0;
      bad_digit  = 1'b0;
      failures   = 0;
      checked    = 0;
    endfunction

    function void emit(logic [BYTE_W-1:0] b, logic [STATUS_W-1:0] st);
      result_t r;
      r.data   = b;
      r.status = st;
      r.last   = 1'b0;
      beat_out = {beat_out, r};
    endfunction

    // every status beat sends the decoder back to hunting for a quote
    function void abort(logic [STATUS_W-1:0] st);
      mode      = AWAIT_QUOTE;
      hex_count = '0;
      emit('0, st);
    endfunction

    function void note_source_beat(logic [BYTE_W-1:0] b, logic src_end);
      logic [3:0]        nib;
      logic [BYTE_W-1:0] plain;
      logic [15:0]       v;
      logic              known;
      beat_out.delete();
      case (mode)
        AWAIT_QUOTE: begin
          if (src_end) begin
            abort(ST_NO_QUOTE);
          end else if (b == CH_QUOTE) begin
            mode = IN_STRING;
          end else if (b != CH_SPACE && b != CH_TAB && b != CH_CR && b != CH_LF) begin
            abort(ST_NO_QUOTE);
          end
        end
        IN_STRING: begin
          if (src_end) abort(ST_UNTERM);
          else if (b == CH_QUOTE) abort(ST_CLOSED);
          else if (b < CH_SPACE) abort(ST_CTRL_CHAR);
          else if (b == CH_BSLASH) mode = AFTER_BACKSLASH;
          else emit(b, ST_DATA);
        end
        AFTER_BACKSLASH: begin
          known = 1'b1;
          plain = '0;
          if (src_end) begin
            abort(ST_END_IN_ESC);
          end else if (b == CH_U) begin
            mode       = IN_HEX;
            hex_count  = '0;
            code_point = '0;
            bad_digit  = 1'b0;
          end else begin
            case (b)
              CH_QUOTE, CH_BSLASH, CH_SLASH: plain = b;
              ESC_B: plain = CH_BKSP;
              ESC_F: plain = CH_FF;
              ESC_N: plain = CH_LF;
              ESC_R: plain = CH_CR;
              ESC_T: plain = CH_TAB;
              default: known = 1'b0;
            endcase
            if (known) begin
              mode = IN_STRING;
              emit(plain, ST_DATA);
            end else begin
              abort(ST_BAD_ESC);
            end
          end
        end
        default: begin
          if (src_end) begin
            abort(ST_SHORT_UNI);
          end else begin
            nib = '0;
            // digits keep their value in the low nibble; letters of either case add nine to it
            if (b >= 8'h30 && b <= 8'h39) nib = b[3:0];
            else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
              nib = b[3:0] + 4'd9;
            else bad_digit = 1'b1;
            code_point = {code_point[11:0], nib};
            if (hex_count != 2'd3) begin
              hex_count = hex_count + 2'd1;
            end else begin
              hex_count = '0;
              if (bad_digit) begin
                abort(ST_BAD_HEX);
              end else begin
                mode = IN_STRING;
                v    = code_point;
                if (v <= 16'h007f) begin
                  emit(v[7:0], ST_DATA);
                end else if (v <= 16'h07ff) begin
                  emit(UTF8_LEAD2 | {3'b0, v[10:6]}, ST_DATA);
                  emit(UTF8_CONT | {2'b0, v[5:0]}, ST_DATA);
                end else begin
                  emit(UTF8_LEAD3 | {4'b0, v[15:12]}, ST_DATA);
                  emit(UTF8_CONT | {2'b0, v[11:6]}, ST_DATA);
                  emit(UTF8_CONT | {2'b0, v[5:0]}, ST_DATA);
                end
              end
            end
          end
        end
      endcase
      if (beat_out.size() > 0) begin
        beat_out[beat_out.size() - 1].last = 1'b1;
      end
      due_results = {due_results, beat_out};
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_result_beat(logic [BYTE_W-1:0] d, logic [STATUS_W-1:0] st, logic l);
      result_t want;
      string   seen;
      seen = $sformatf("byte %02h status %0d last %0b", d, st, l);
      if (due_results.size() == 0) begin
        flag($sformatf("unexpected result beat: %s", seen));
      end else begin
        want = due_results.pop_front();
        if (want.data !== d || want.status !== st || want.last !== l)
          flag($sformatf("result %0d: expected byte %02h status %0d last %0b, got %s",
                         checked, want.data, want.status, want.last, seen));
        checked++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic calm;          // high while neither side may idle
  int unsigned items_sent;
  int unsigned quiet_cycles;

  jsu_in_if  in_if ();
  jsu_out_if out_if ();

  unescape_scoreboard sb = new();

  json_string_unescape DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // valid letters after a backslash; the unicode introducer comes last
  function automatic logic [BYTE_W-1:0] escape_letter(int unsigned idx);
    case (idx)
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return ESC_B;
      4: return ESC_F;
      5: return ESC_N;
      6: return ESC_R;
      7: return ESC_T;
      default: return CH_U;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] hex_char(logic [3:0] nib, logic upper);
    if (nib < 4'd10) return 8'h30 + nib;
    return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  // random digit in either letter case
  function automatic logic [BYTE_W-1:0] rand_hex_char();
    return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [BYTE_W-1:0] rand_bad_digit();
    logic [BYTE_W-1:0] b;
    do begin
      b = BYTE_W'($urandom_range(0, 255));
    end while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66));
    return b;
  endfunction

  // one source beat: random idle first, then hold valid until it is taken
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic src_end);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.byte_req   <= b;
    in_if.source_end <= src_end;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send_end();
    send_beat(BYTE_W'($urandom_range(0, 255)), 1'b1);  // byte is don't-care on an end beat
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // drop valid and let every owed result drain out
  task automatic hold_until_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
  endtask

  // accepted beats on both streams, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_source_beat(in_if.byte_req, in_if.source_end);
      if (out_if.valid && out_if.ready)
        sb.check_result_beat(out_if.out_byte, out_if.status, out_if.last);
    end
  end

  // watchdog: too long without any beat moving on either stream
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side backpressure
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  initial begin
    int unsigned       n;
    int unsigned       break_at;
    int unsigned       goal;
    int unsigned       calm_from;
    int unsigned       bad_pos;
    logic              broken;
    logic [15:0]       cp;
    logic [BYTE_W-1:0] b;
    logic              ok;

    rst_n            = 1'b0;
    calm             = 1'b0;
    items_sent       = 0;
    quiet_cycles     = 0;
    in_if.valid      = 1'b0;
    in_if.byte_req   = '0;
    in_if.source_end = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    send_end();                      // source ends before any string: no quote
    send_beat(8'h00, 1'b0);          // junk while waiting, lowest byte
    send_text(" \t\"");              // whitespace is skipped, then the string opens
    send_beat(8'hff, 1'b0);          // high bytes pass straight through
    send_beat(CH_DEL, 1'b0);         // so does delete
    send_beat(8'h1f, 1'b0);          // control character ends the string in error
    send_text("\"\\q");              // unknown escape letter
    send_text("\"\\");
    send_end();                      // source ends right after a backslash
    send_text("\"\\uz1");
    send_end();                      // short unicode wins over the bad digit already seen
    send_text("\"\\uG000");          // bad digit only reported after the fourth
    send_text("\"");
    send_end();                      // unterminated string
    send_text("\"\\uFfFf\"");        // largest code point, three utf-8 bytes, then closed

    // sender waits for the result stream to run dry at least once
    hold_until_drained();

    // ---- random part: mostly well-formed strings, some noise and breakage ----
    goal      = items_sent + RANDOM_BEATS;
    calm_from = items_sent + $urandom_range(20, 50);
    while (items_sent < goal) begin
      calm = (items_sent >= calm_from) && (items_sent < calm_from + CALM_BEATS);

      if ($urandom_range(0, 99) < 12) begin
        // noise between strings
        case ($urandom_range(0, 2))
          0: send_end();
          1: send_beat(BYTE_W'($urandom_range(0, 255)), 1'b0);
          default: send_beat(BYTE_W'($urandom_range(0, 31)), 1'b0);
        endcase
      end else begin
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 3))
            0: b = CH_SPACE;
            1: b = CH_TAB;
            2: b = CH_CR;
            default: b = CH_LF;
          endcase
          send_beat(b, 1'b0);
        end
        send_beat(CH_QUOTE, 1'b0);

        n        = $urandom_range(0, 8);
        broken   = ($urandom_range(0, 99) < 20);
        break_at = $urandom_range(0, n);
        for (int i = 0; i < n; i++) begin
          if (broken && i == break_at) break;
          case ($urandom_range(0, 9))
            5, 6: begin
              send_beat(CH_BSLASH, 1'b0);
              send_beat(escape_letter($urandom_range(0, 7)), 1'b0);
            end
            7, 8, 9: begin
              // spread code points over one, two and three byte encodings and surrogates
              case ($urandom_range(0, 3))
                0: cp = 16'($urandom_range(16'h0000, 16'h007f));
                1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
                2: cp = 16'($urandom_range(16'h0800, 16'hffff));
                default: cp = 16'($urandom_range(16'hd800, 16'hdfff));
              endcase
              send_beat(CH_BSLASH, 1'b0);
              send_beat(CH_U, 1'b0);
              for (int d = 3; d >= 0; d--)
                send_beat(hex_char(cp[d*4 +: 4], 1'($urandom_range(0, 1))), 1'b0);
            end
            default: begin
              do begin
                b = BYTE_W'($urandom_range(32, 255));
              end while (b == CH_QUOTE || b == CH_BSLASH);
              send_beat(b, 1'b0);
            end
          endcase
        end

        if (!broken) begin
          send_beat(CH_QUOTE, 1'b0);
        end else begin
          case ($urandom_range(0, 5))
            0: send_end();
            1: send_beat(BYTE_W'($urandom_range(0, 31)), 1'b0);
            2: begin
              send_beat(CH_BSLASH, 1'b0);
              do begin
                b  = BYTE_W'($urandom_range(0, 255));
                ok = 1'b1;
                for (int j = 0; j <= 8; j++) if (b == escape_letter(j)) ok = 1'b0;
              end while (!ok);
              send_beat(b, 1'b0);
            end
            3: begin
              send_beat(CH_BSLASH, 1'b0);
              send_end();
            end
            4: begin
              // escape cut short, possibly with a bad digit inside
              send_beat(CH_BSLASH, 1'b0);
              send_beat(CH_U, 1'b0);
              repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 3) == 0) send_beat(rand_bad_digit(), 1'b0);
                else send_beat(rand_hex_char(), 1'b0);
              end
              send_end();
            end
            default: begin
              send_beat(CH_BSLASH, 1'b0);
              send_beat(CH_U, 1'b0);
              bad_pos = $urandom_range(0, 3);
              for (int d = 0; d < 4; d++) begin
                if (d == bad_pos) send_beat(rand_bad_digit(), 1'b0);
                else send_beat(rand_hex_char(), 1'b0);
              end
            end
          endcase
        end
      end

      if ($urandom_range(0, 19) == 0) hold_until_drained();
    end
    calm = 1'b0;

    // wind down: everything owed must arrive, then nothing more may appear
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
